// ===== rtl/esc_pkg.sv =====
// ----------------------------------------------------------------------------
// esc_pkg: shared types and constants for the sensor compensation block
// Item layouts, register indexes, reset values, divider context.
// ----------------------------------------------------------------------------
package esc_pkg;

  typedef struct packed {
    logic [19:0] raw_temp;
    logic [19:0] raw_press;
    logic [15:0] raw_hum;
  } in_item_t;

  typedef struct packed {
    logic signed [19:0] temperature_centi;
    logic signed [31:0] pressure_q8;
    logic               pressure_invalid;
    logic [7:0]         humidity_pct;
  } out_item_t;

  localparam int unsigned CFG_DW = 64;
  localparam int unsigned CFG_IW = 4;

  typedef enum logic [CFG_IW-1:0] {
    CFG_TEMP_CAL       = 4'd0,
    CFG_PRESS_CAL_LOW  = 4'd1,
    CFG_PRESS_CAL_HIGH = 4'd2,
    CFG_MIXED_CAL      = 4'd3,
    CFG_HUM_CAL        = 4'd4,
    CFG_TEMP_OFFSET    = 4'd5,
    CFG_PRESS_OFFSET   = 4'd6,
    CFG_HUM_OFFSET     = 4'd7
  } cfg_idx_e;

  localparam logic signed [15:0] TEMP_OFF_RST  = 16'sd16700;
  localparam logic [23:0]        PRESS_OFF_RST = 24'd3660800;
  localparam logic [7:0]         HUM_OFF_RST   = 8'd9;

  // quotient magnitude ceiling, 2^35 - 1
  localparam logic [34:0]        QUOT_LIMIT = 35'h7_FFFF_FFFF;
  localparam logic signed [32:0] HUM_CEIL   = 33'sd419430400;

  // one quotient bit per stage
  localparam int unsigned DIV_STEPS = 36;

  typedef struct packed {
    logic [47:0]        rem;
    logic [35:0]        low;
    logic [35:0]        quo;
    logic [47:0]        ad;
    logic               sat;
    logic               neg;
    logic               inv;
    logic signed [19:0] tc;
    logic signed [69:0] uv;
  } div_ctx_t;

endpackage

// ===== rtl/env_sensor_compensation.sv =====
// ----------------------------------------------------------------------------
// env_sensor_compensation: integer temperature, pressure, humidity compensation
// Fifty-five stage pipeline; pressure quotient by a bit-per-stage divider.
// ----------------------------------------------------------------------------
//
//  channel  | signals                                   | direction
//  ---------+-------------------------------------------+----------
//  input    | in_valid_i, in_stall_o, in_item_i         | in
//  output   | out_valid_o, out_stall_i, out_item_o      | out
//  config   | cfg_we_i, cfg_idx_i, cfg_data_i           | in
//
//  One item enters per cycle while no output item is held; the pipeline has
//  13 arithmetic stages, 36 divider stages and 6 post stages. The depth is set by the restoring
//  divider that yields one quotient bit per stage.
//  Reset clears the valid line and loads register defaults.
//  A stall on a valid output item freezes the whole pipeline; in_stall_o follows it.
//
module env_sensor_compensation (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  esc_pkg::in_item_t           in_item_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output esc_pkg::out_item_t          out_item_o,
  input  logic                        cfg_we_i,
  input  logic [esc_pkg::CFG_IW-1:0]  cfg_idx_i,
  input  logic [esc_pkg::CFG_DW-1:0]  cfg_data_i
);

  localparam int unsigned NST = 13 + esc_pkg::DIV_STEPS + 6;

  // --------------------------------------------------------------------------
  // configuration registers
  // --------------------------------------------------------------------------
  logic [47:0]        tcal_q;
  logic [63:0]        pcl_q, pch_q;
  logic [47:0]        mix_q;
  logic [39:0]        hcal_q;
  logic signed [15:0] toff_q;
  logic [23:0]        poff_q;
  logic [7:0]         hoff_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tcal_q <= '0;
      pcl_q  <= '0;
      pch_q  <= '0;
      mix_q  <= '0;
      hcal_q <= '0;
      toff_q <= esc_pkg::TEMP_OFF_RST;
      poff_q <= esc_pkg::PRESS_OFF_RST;
      hoff_q <= esc_pkg::HUM_OFF_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        esc_pkg::CFG_TEMP_CAL:       tcal_q <= cfg_data_i[47:0];
        esc_pkg::CFG_PRESS_CAL_LOW:  pcl_q  <= cfg_data_i;
        esc_pkg::CFG_PRESS_CAL_HIGH: pch_q  <= cfg_data_i;
        esc_pkg::CFG_MIXED_CAL:      mix_q  <= cfg_data_i[47:0];
        esc_pkg::CFG_HUM_CAL:        hcal_q <= cfg_data_i[39:0];
        esc_pkg::CFG_TEMP_OFFSET:    toff_q <= $signed(cfg_data_i[15:0]);
        esc_pkg::CFG_PRESS_OFFSET:   poff_q <= cfg_data_i[23:0];
        esc_pkg::CFG_HUM_OFFSET:     hoff_q <= cfg_data_i[7:0];
        default: ;  // unknown index: ignored
      endcase
    end
  end

  // calibration words
  logic signed [15:0] t2, t3, p2, p3, p4, p5, p6, p7, p8, p9, h2, h4, h5;
  logic signed [16:0] p1s;
  logic signed [8:0]  h1s, h3s;
  logic signed [7:0]  h6;

  assign t2  = $signed(tcal_q[31:16]);
  assign t3  = $signed(tcal_q[47:32]);
  assign p1s = $signed({1'b0, pcl_q[15:0]});
  assign p2  = $signed(pcl_q[31:16]);
  assign p3  = $signed(pcl_q[47:32]);
  assign p4  = $signed(pcl_q[63:48]);
  assign p5  = $signed(pch_q[15:0]);
  assign p6  = $signed(pch_q[31:16]);
  assign p7  = $signed(pch_q[47:32]);
  assign p8  = $signed(pch_q[63:48]);
  assign p9  = $signed(mix_q[15:0]);
  assign h1s = $signed({1'b0, mix_q[23:16]});
  assign h2  = $signed(mix_q[39:24]);
  assign h3s = $signed({1'b0, mix_q[47:40]});
  assign h4  = $signed(hcal_q[15:0]);
  assign h5  = $signed(hcal_q[31:16]);
  assign h6  = $signed(hcal_q[39:32]);

  // --------------------------------------------------------------------------
  // flow control: the whole line advances unless the output item is held
  // --------------------------------------------------------------------------
  logic [NST-1:0] vld_q;
  logic           en;

  assign en          = !(vld_q[NST-1] && out_stall_i);
  assign in_stall_o  = !en;
  assign out_valid_o = vld_q[NST-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[NST-2:0], in_valid_i};
    end
  end

  // --------------------------------------------------------------------------
  // stage 1-6: fine temperature and temperature result
  // --------------------------------------------------------------------------
  logic signed [18:0] s1_a1_q, s1_a1_d;
  logic signed [17:0] s1_d_q, s1_d_d;
  logic signed [34:0] s2_pt2_q, s2_pt2_d;
  logic signed [35:0] s2_dd_q, s2_dd_d;
  logic signed [23:0] s3_v1_q, s3_v1_d, s4_v1_q;
  logic signed [23:0] s3_w_q, s3_w_d;
  logic signed [39:0] s4_m_q, s4_m_d;
  logic signed [34:0] tz11;
  logic signed [39:0] tz14;
  logic signed [24:0] s5_tf_q, s5_tf_d;
  logic signed [27:0] tf_ext, t5;
  logic signed [19:0] tc0;
  logic signed [20:0] tcs;
  logic signed [19:0] s6_tc_q, s6_tc_d;
  logic signed [25:0] s6_x_q, s6_x_d, s6_xh_q, s6_xh_d;

  logic [19:0] rp_line_q [9];   // raw pressure, stages 1..9
  logic [15:0] rh_line_q [6];   // raw humidity, stages 1..6

  always_comb begin
    s1_a1_d = $signed({2'b0, in_item_i.raw_temp[19:3]})
            - $signed({1'b0, tcal_q[15:0], 1'b0});
    s1_d_d  = $signed({2'b0, in_item_i.raw_temp[19:4]}) - $signed({2'b0, tcal_q[15:0]});
    s2_pt2_d = s1_a1_q * t2;
    s2_dd_d  = s1_d_q * s1_d_q;
    // divisions truncate toward zero
    tz11    = s2_pt2_q[34] ? -((-s2_pt2_q) >>> 11) : (s2_pt2_q >>> 11);
    s3_v1_d = $signed(tz11[23:0]);
    s3_w_d  = $signed(s2_dd_q[35:12]);
    s4_m_d  = s3_w_q * t3;
    tz14    = s4_m_q[39] ? -((-s4_m_q) >>> 14) : (s4_m_q >>> 14);
    s5_tf_d = s4_v1_q + $signed(tz14[24:0]);
    // temperature in hundredths, offset and saturation
    tf_ext  = $signed({{3{s5_tf_q[24]}}, s5_tf_q});
    t5      = tf_ext * 28'sd5 + 28'sd128;
    tc0     = $signed(t5[27:8]);
    tcs     = $signed({tc0[19], tc0}) + $signed({{5{toff_q[15]}}, toff_q});
    if (tcs > 21'sd524287) begin
      s6_tc_d = 20'sd524287;
    end else if (tcs < -21'sd524288) begin
      s6_tc_d = -20'sd524288;
    end else begin
      s6_tc_d = $signed(tcs[19:0]);
    end
    s6_x_d  = $signed({s5_tf_q[24], s5_tf_q}) - 26'sd128000;
    s6_xh_d = $signed({s5_tf_q[24], s5_tf_q}) - 26'sd76800;
  end

  // --------------------------------------------------------------------------
  // stage 7-12: pressure polynomial, divisor, numerator; humidity terms
  // --------------------------------------------------------------------------
  logic signed [51:0] s7_xx_q, s7_xx_d;
  logic signed [41:0] s7_xp5_q, s7_xp5_d, s7_xp2_q, s7_xp2_d, s8_xp5_q, s8_xp2_q;
  logic signed [33:0] s7_m6_q, s7_m6_d;
  logic signed [34:0] s7_m3_q, s7_m3_d;
  logic signed [41:0] s7_h5x_q, s7_h5x_d;
  logic signed [37:0] s7_ub_q, s7_ub_d;
  logic signed [67:0] xxp6_full, xxp3_full;
  logic signed [63:0] s8_xxp6_q, s8_xxp6_d, s8_xxp3_q, s8_xxp3_d;
  logic signed [42:0] usum;
  logic signed [27:0] s8_u_q, s8_u_d, s9_u_q, s10_u_q, s11_u_q, s12_u_q;
  logic signed [23:0] s8_t6_q, s8_t6_d;
  logic signed [24:0] s8_t3p_q, s8_t3p_d;
  logic signed [63:0] s9_b_q, s9_b_d, s9_a_q, s9_a_d;
  logic signed [48:0] s9_pr_q, s9_pr_d;
  logic signed [47:0] s10_dhi_q, s10_dhi_d;
  logic [48:0]        dlo_full;
  logic [15:0]        s10_dlo_q, s10_dlo_d;
  logic signed [64:0] s10_num_q, s10_num_d;
  logic signed [39:0] s10_w_q, s10_w_d;
  logic signed [48:0] s11_den_q, s11_den_d;
  logic signed [64:0] nabs;
  logic [63:0]        s11_an_q, s11_an_d;
  logic               s11_nneg_q;
  logic signed [55:0] s11_wh_q, s11_wh_d;
  logic signed [48:0] dabs;
  logic [47:0]        s12_ad_q, s12_ad_d;
  logic               s12_inv_q, s12_neg_q;
  logic [43:0]        s12_nlo_q, s12_nlo_d, s12_nhi_q, s12_nhi_d;
  logic signed [55:0] vw;
  logic signed [41:0] s12_v_q, s12_v_d;

  logic signed [19:0] tc_line_q [6];   // temperature result, stages 7..12

  always_comb begin
    s7_xx_d  = s6_x_q * s6_x_q;
    s7_xp5_d = s6_x_q * p5;
    s7_xp2_d = s6_x_q * p2;
    s7_m6_d  = s6_xh_q * h6;
    s7_m3_d  = s6_xh_q * h3s;
    s7_h5x_d = s6_xh_q * h5;
    s7_ub_d  = $signed({8'b0, rh_line_q[5], 14'b0}) - $signed({h4, 20'b0}) + 38'sd16384;

    xxp6_full = s7_xx_q * p6;
    xxp3_full = s7_xx_q * p3;
    s8_xxp6_d = $signed(xxp6_full[63:0]);
    s8_xxp3_d = $signed(xxp3_full[63:0]);
    usum      = s7_ub_q - s7_h5x_q;
    s8_u_d    = $signed(usum[42:15]);
    s8_t6_d   = $signed(s7_m6_q[33:10]);
    s8_t3p_d  = $signed({s7_m3_q[34], s7_m3_q[34:11]}) + 25'sd32768;

    s9_b_d  = s8_xxp6_q + $signed({{5{s8_xp5_q[41]}}, s8_xp5_q, 17'b0})
            + $signed({{13{p4[15]}}, p4, 35'b0});
    s9_a_d  = 64'sd140737488355328 + $signed({{8{s8_xxp3_q[63]}}, s8_xxp3_q[63:8]})
            + $signed({{10{s8_xp2_q[41]}}, s8_xp2_q, 12'b0});
    s9_pr_d = s8_t6_q * s8_t3p_q;

    // divisor: high part of a times P1 plus the carry-in of the low part
    s10_dhi_d = $signed(s9_a_q[63:33]) * p1s;
    dlo_full  = s9_a_q[32:0] * pcl_q[15:0];
    s10_dlo_d = dlo_full[48:33];
    s10_num_d = $signed({1'b0, 21'd1048576 - {1'b0, rp_line_q[8]}, 31'b0}) - s9_b_q;
    s10_w_d   = $signed({s9_pr_q[48], s9_pr_q[48:10]}) + 40'sd2097152;

    s11_den_d = s10_dhi_q + $signed({1'b0, s10_dlo_q});
    nabs      = s10_num_q[64] ? -s10_num_q : s10_num_q;
    s11_an_d  = nabs[63:0];
    s11_wh_d  = s10_w_q * h2;

    dabs      = s11_den_q[48] ? -s11_den_q : s11_den_q;
    s12_ad_d  = dabs[47:0];
    s12_nlo_d = s11_an_q[31:0] * 12'd3125;
    s12_nhi_d = s11_an_q[63:32] * 12'd3125;
    vw        = s11_wh_q + 56'sd8192;
    s12_v_d   = $signed(vw[55:14]);
  end

  // --------------------------------------------------------------------------
  // stage 13: scaled numerator, overflow test, divider entry
  // --------------------------------------------------------------------------
  logic [75:0]        nfull;
  logic               sat0;
  esc_pkg::div_ctx_t  div_in;
  esc_pkg::div_ctx_t  div_q  [esc_pkg::DIV_STEPS+1];
  esc_pkg::div_ctx_t  div_nx [esc_pkg::DIV_STEPS];

  always_comb begin
    nfull = {s12_nhi_q, 32'b0} + {32'b0, s12_nlo_q};
    // quotient at or above 2^36 saturates
    sat0  = {8'b0, nfull[75:36]} >= s12_ad_q;
    div_in.rem = sat0 ? '0 : {8'b0, nfull[75:36]};
    div_in.low = nfull[35:0];
    div_in.quo = '0;
    div_in.ad  = s12_ad_q;
    div_in.sat = sat0;
    div_in.neg = s12_neg_q;
    div_in.inv = s12_inv_q;
    div_in.tc  = tc_line_q[5];
    div_in.uv  = s12_u_q * s12_v_q;
  end

  // restoring division, one quotient bit per stage
  always_comb begin
    logic [48:0] trial;
    logic        ge;
    for (int k = 0; k < esc_pkg::DIV_STEPS; k++) begin
      trial          = {div_q[k].rem, div_q[k].low[35]};
      ge             = trial >= {1'b0, div_q[k].ad};
      div_nx[k]      = div_q[k];
      div_nx[k].rem  = ge ? (trial[47:0] - div_q[k].ad) : trial[47:0];
      div_nx[k].low  = {div_q[k].low[34:0], 1'b0};
      div_nx[k].quo  = {div_q[k].quo[34:0], ge};
    end
  end

  // --------------------------------------------------------------------------
  // post stages P1-P6: pressure corrections, humidity finish, output
  // --------------------------------------------------------------------------
  esc_pkg::div_ctx_t  dq;
  logic [34:0]        mag;
  logic signed [35:0] p1_qs_q, p1_qs_d, p2_qs_q, p3_qs_q, p4_qs_q;
  logic signed [31:0] p1_vc_q, p1_vc_d, p2_vc_q, p3_vc_q;
  logic signed [22:0] p2_qs13_q, p2_qs13_d;
  logic signed [51:0] p2_p8q_q, p2_p8q_d, p3_p8q_q, p4_p8q_q;
  logic signed [16:0] hs;
  logic signed [33:0] p2_ss_q, p2_ss_d;
  logic signed [45:0] p3_sq_q, p3_sq_d;
  logic signed [35:0] p3_sh_q, p3_sh_d;
  logic signed [61:0] p4_r1m_q, p4_r1m_d;
  logic signed [32:0] v2, v2c;
  logic [7:0]         p4_hum_q, p4_hum_d, p5_hum_q;
  logic signed [38:0] psum;
  logic signed [32:0] p5_pv_q, p5_pv_d;
  logic signed [33:0] psd;
  esc_pkg::out_item_t out_d, out_q;
  logic               p1_inv_q, p2_inv_q, p3_inv_q, p4_inv_q, p5_inv_q;
  logic signed [19:0] p1_tc_q, p2_tc_q, p3_tc_q, p4_tc_q, p5_tc_q;

  assign dq = div_q[esc_pkg::DIV_STEPS];

  always_comb begin
    mag     = (dq.sat || dq.quo[35]) ? esc_pkg::QUOT_LIMIT : dq.quo[34:0];
    p1_qs_d = dq.neg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
    if (dq.uv > 70'sd2147483647) begin
      p1_vc_d = 32'sh7FFF_FFFF;
    end else if (dq.uv < -70'sd2147483648) begin
      p1_vc_d = 32'sh8000_0000;
    end else begin
      p1_vc_d = $signed(dq.uv[31:0]);
    end

    p2_qs13_d = $signed(p1_qs_q[35:13]);
    p2_p8q_d  = p8 * p1_qs_q;
    hs        = $signed(p1_vc_q[31:15]);
    p2_ss_d   = hs * hs;

    p3_sq_d   = p2_qs13_q * p2_qs13_q;
    p3_sh_d   = $signed(p2_ss_q[33:7]) * h1s;

    p4_r1m_d  = p3_sq_q * p9;
    v2        = $signed({p3_vc_q[31], p3_vc_q}) - $signed({p3_sh_q[35], p3_sh_q[35:4]});
    if (v2 < 33'sd0) begin
      v2c = '0;
    end else if (v2 > esc_pkg::HUM_CEIL) begin
      v2c = esc_pkg::HUM_CEIL;
    end else begin
      v2c = v2;
    end
    p4_hum_d  = {1'b0, v2c[28:22]} + hoff_q;

    psum      = $signed({{3{p4_qs_q[35]}}, p4_qs_q})
              + $signed({{2{p4_r1m_q[61]}}, p4_r1m_q[61:25]})
              + $signed({{6{p4_p8q_q[51]}}, p4_p8q_q[51:19]});
    p5_pv_d   = p4_inv_q ? '0
              : ($signed({{2{psum[38]}}, psum[38:8]}) + $signed({{13{p7[15]}}, p7, 4'b0}));

    psd       = $signed({p5_pv_q[32], p5_pv_q}) - $signed({10'b0, poff_q});
    if (psd > 34'sd2147483647) begin
      out_d.pressure_q8 = 32'sh7FFF_FFFF;
    end else if (psd < -34'sd2147483648) begin
      out_d.pressure_q8 = 32'sh8000_0000;
    end else begin
      out_d.pressure_q8 = $signed(psd[31:0]);
    end
    out_d.temperature_centi = p5_tc_q;
    out_d.pressure_invalid  = p5_inv_q;
    out_d.humidity_pct      = p5_hum_q;
  end

  assign out_item_o = out_q;

  // --------------------------------------------------------------------------
  // payload registers, all moved by the common enable
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_a1_q <= s1_a1_d;
      s1_d_q  <= s1_d_d;
      rp_line_q[0] <= in_item_i.raw_press;
      rh_line_q[0] <= in_item_i.raw_hum;
      for (int i = 1; i < 9; i++) rp_line_q[i] <= rp_line_q[i-1];
      for (int i = 1; i < 6; i++) rh_line_q[i] <= rh_line_q[i-1];
      s2_pt2_q <= s2_pt2_d;
      s2_dd_q  <= s2_dd_d;
      s3_v1_q  <= s3_v1_d;
      s3_w_q   <= s3_w_d;
      s4_v1_q  <= s3_v1_q;
      s4_m_q   <= s4_m_d;
      s5_tf_q  <= s5_tf_d;
      s6_tc_q  <= s6_tc_d;
      s6_x_q   <= s6_x_d;
      s6_xh_q  <= s6_xh_d;
      tc_line_q[0] <= s6_tc_q;
      for (int i = 1; i < 6; i++) tc_line_q[i] <= tc_line_q[i-1];
      s7_xx_q  <= s7_xx_d;
      s7_xp5_q <= s7_xp5_d;
      s7_xp2_q <= s7_xp2_d;
      s7_m6_q  <= s7_m6_d;
      s7_m3_q  <= s7_m3_d;
      s7_h5x_q <= s7_h5x_d;
      s7_ub_q  <= s7_ub_d;
      s8_xxp6_q <= s8_xxp6_d;
      s8_xxp3_q <= s8_xxp3_d;
      s8_xp5_q  <= s7_xp5_q;
      s8_xp2_q  <= s7_xp2_q;
      s8_u_q    <= s8_u_d;
      s8_t6_q   <= s8_t6_d;
      s8_t3p_q  <= s8_t3p_d;
      s9_b_q    <= s9_b_d;
      s9_a_q    <= s9_a_d;
      s9_pr_q   <= s9_pr_d;
      s9_u_q    <= s8_u_q;
      s10_dhi_q <= s10_dhi_d;
      s10_dlo_q <= s10_dlo_d;
      s10_num_q <= s10_num_d;
      s10_w_q   <= s10_w_d;
      s10_u_q   <= s9_u_q;
      s11_den_q  <= s11_den_d;
      s11_an_q   <= s11_an_d;
      s11_nneg_q <= s10_num_q[64];
      s11_wh_q   <= s11_wh_d;
      s11_u_q    <= s10_u_q;
      s12_ad_q  <= s12_ad_d;
      s12_inv_q <= (s11_den_q == 49'sd0);
      s12_neg_q <= s11_nneg_q ^ s11_den_q[48];
      s12_nlo_q <= s12_nlo_d;
      s12_nhi_q <= s12_nhi_d;
      s12_v_q   <= s12_v_d;
      s12_u_q   <= s11_u_q;
      div_q[0]  <= div_in;
      for (int k = 0; k < esc_pkg::DIV_STEPS; k++) div_q[k+1] <= div_nx[k];
      p1_qs_q   <= p1_qs_d;
      p1_vc_q   <= p1_vc_d;
      p1_inv_q  <= dq.inv;
      p1_tc_q   <= dq.tc;
      p2_qs_q   <= p1_qs_q;
      p2_qs13_q <= p2_qs13_d;
      p2_p8q_q  <= p2_p8q_d;
      p2_ss_q   <= p2_ss_d;
      p2_vc_q   <= p1_vc_q;
      p2_inv_q  <= p1_inv_q;
      p2_tc_q   <= p1_tc_q;
      p3_qs_q   <= p2_qs_q;
      p3_sq_q   <= p3_sq_d;
      p3_p8q_q  <= p2_p8q_q;
      p3_sh_q   <= p3_sh_d;
      p3_vc_q   <= p2_vc_q;
      p3_inv_q  <= p2_inv_q;
      p3_tc_q   <= p2_tc_q;
      p4_qs_q   <= p3_qs_q;
      p4_r1m_q  <= p4_r1m_d;
      p4_p8q_q  <= p3_p8q_q;
      p4_hum_q  <= p4_hum_d;
      p4_inv_q  <= p3_inv_q;
      p4_tc_q   <= p3_tc_q;
      p5_pv_q   <= p5_pv_d;
      p5_hum_q  <= p4_hum_q;
      p5_inv_q  <= p4_inv_q;
      p5_tc_q   <= p4_tc_q;
      out_q     <= out_d;
    end
  end

`ifndef ASSERT_OFF
  // an accepted item shows up in the first stage
  a_accept_enters : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> vld_q[0])
    else $error("accepted item missing from stage 1");

  // a held output freezes every valid bit
  a_stall_holds : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |=> $stable(vld_q))
    else $error("pipeline moved during stall");

  // divider remainder stays below the divisor
  a_rem_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q[12 + esc_pkg::DIV_STEPS] && !dq.sat) |-> (dq.rem < dq.ad))
    else $error("divider remainder out of range");
`endif

endmodule
